@@ rtl/core/postfix_stack_evaluator_assert.svh @@
// Assertion macros shared by the postfix stack evaluator modules.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PSE_ASSERT_HOLD(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a same-cycle implication outside reset.
`define PSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication outside reset.
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pse_pkg.sv @@
// Shared types and constants of the postfix stack evaluator.
package pse_pkg;

  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DFIN,
    S_WB
  } state_t;

  typedef struct packed {
    logic       push;
    logic       rd;
    logic       alu_add;
    logic       alu_sub;
    logic       mul_start;
    logic       mul_fin;
    logic       div_sat;
    logic       div_start;
    logic       div_step;
    logic       div_fin;
    logic       wb;
    logic       respond;
    logic [2:0] code;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic lt2;
    logic first_zero;
    logic div_ovf;
    logic div_last;
    logic sat;
  } sts_t;

endpackage

@@ rtl/core/pse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/pse_ctrl.sv @@
// Controller state machine of the postfix stack evaluator.
`include "postfix_stack_evaluator_assert.svh"

module pse_ctrl
  import pse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] command,
  input  sts_t       sts,
  output ctl_t       ctl,
  output logic       busy
);

  state_t     state;
  state_t     state_next;
  logic [2:0] op;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op <= command;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.code   = ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (command)
            CMD_PUSH: begin
              ctl.respond = 1'b1;
              if (sts.full) begin
                ctl.code = ST_OVER;
              end else begin
                ctl.push = 1'b1;
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (sts.lt2) begin
                ctl.respond = 1'b1;
                ctl.code    = ST_UNDER;
              end else begin
                ctl.rd     = 1'b1;
                state_next = S_EXEC;
              end
            end
            default: begin
              ctl.respond = 1'b1;
            end
          endcase
        end
      end
      S_EXEC: begin
        case (op)
          CMD_ADD: begin
            ctl.alu_add = 1'b1;
            state_next  = S_WB;
          end
          CMD_SUB: begin
            ctl.alu_sub = 1'b1;
            state_next  = S_WB;
          end
          CMD_MUL: begin
            ctl.mul_start = 1'b1;
            state_next    = S_MUL;
          end
          CMD_DIV: begin
            if (sts.first_zero) begin
              ctl.respond = 1'b1;
              ctl.code    = ST_DIVZ;
              state_next  = S_IDLE;
            end else if (sts.div_ovf) begin
              ctl.div_sat = 1'b1;
              state_next  = S_WB;
            end else begin
              ctl.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          default: begin
            ctl.respond = 1'b1;
            state_next  = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        ctl.mul_fin = 1'b1;
        state_next  = S_WB;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DFIN;
        end
      end
      S_DFIN: begin
        ctl.div_fin = 1'b1;
        state_next  = S_WB;
      end
      S_WB: begin
        ctl.wb      = 1'b1;
        ctl.respond = 1'b1;
        ctl.code    = sts.sat ? ST_SAT : ST_OK;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `PSE_ASSERT_NEXT(a_wb_returns, state == S_WB, state == S_IDLE, "write-back did not end request")
  `PSE_ASSERT_IMP(a_exec_from_idle, state == S_EXEC, $past(state) == S_IDLE, "exec not after idle")
  `PSE_ASSERT_IMP(a_dfin_from_div, state == S_DFIN, $past(state) == S_DIV, "divide finish out of order")

endmodule

@@ rtl/core/pse_dp.sv @@
// Datapath of the postfix stack evaluator: stack, top register and arithmetic.
`include "postfix_stack_evaluator_assert.svh"

module pse_dp
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  input  logic signed [31:0] operand_value,
  output sts_t               sts,
  output logic               done,
  output logic signed [31:0] top_value,
  output logic [4:0]         stack_level,
  output logic [2:0]         status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_m2;
  logic [CW+4:0]      count_ext;
  logic [31:0]        top_reg;
  logic [31:0]        res;
  logic               sat;
  logic [2:0]         status_reg;
  logic               done_reg;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic [31:0]        second;

  logic [32:0]        sum;
  logic signed [63:0] prod;
  logic signed [47:0] mq;
  logic signed [47:0] madj;
  logic               mround;

  logic [31:0]        abs_s;
  logic [31:0]        abs_f;
  logic               neg;
  logic [32:0]        rem;
  logic [32:0]        rem_sh;
  logic [32:0]        diff;
  logic [31:0]        dq;
  logic [31:0]        dvs;
  logic [4:0]         step;
  logic [32:0]        qneg;

  assign count_m2  = count - CW'(2);
  assign ram_we    = ctl.push | ctl.wb;
  assign ram_waddr = ctl.push ? count[AW-1:0] : count_m2[AW-1:0];
  assign ram_wdata = ctl.push ? operand_value : res;

  pse_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.rd),
    .raddr (count_m2[AW-1:0]),
    .rdata (second)
  );

  assign abs_s = second[31] ? (32'd0 - second) : second;
  assign abs_f = top_reg[31] ? (32'd0 - top_reg) : top_reg;

  always_comb begin
    if (ctl.alu_sub) begin
      sum = {second[31], second} - {top_reg[31], top_reg};
    end else begin
      sum = {second[31], second} + {top_reg[31], top_reg};
    end
  end

  assign mq     = $signed(prod[63:16]);
  assign mround = prod[63] && (prod[15:0] != 16'd0);
  assign madj   = mq + 48'(mround);

  assign rem_sh = {rem[31:0], dq[31]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign qneg   = 33'd0 - {1'b0, dq};

  assign sts.full       = (count == CW'(STACK_DEPTH));
  assign sts.lt2        = (count < CW'(2));
  assign sts.first_zero = (top_reg == 32'd0);
  assign sts.div_ovf    = ({16'd0, abs_s[31:16]} >= abs_f);
  assign sts.div_last   = (step == 5'd31);
  assign sts.sat        = sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      done_reg <= 1'b0;
    end else begin
      done_reg <= ctl.respond;
      if (ctl.push) begin
        count <= count + CW'(1);
      end else if (ctl.wb) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.respond) begin
      status_reg <= ctl.code;
    end
    if (ctl.push) begin
      top_reg <= operand_value;
    end else if (ctl.wb) begin
      top_reg <= res;
    end
    if (ctl.alu_add || ctl.alu_sub) begin
      sat <= (sum[32] != sum[31]);
      res <= (sum[32] != sum[31]) ? (sum[32] ? Q_MIN : Q_MAX) : sum[31:0];
    end
    if (ctl.mul_start) begin
      prod <= $signed(second) * $signed(top_reg);
    end
    if (ctl.mul_fin) begin
      sat <= (madj[47:31] != {17{madj[31]}});
      res <= (madj[47:31] != {17{madj[31]}}) ? (madj[47] ? Q_MIN : Q_MAX) : madj[31:0];
    end
    if (ctl.div_sat) begin
      sat <= 1'b1;
      res <= (second[31] ^ top_reg[31]) ? Q_MIN : Q_MAX;
    end
    if (ctl.div_start) begin
      rem  <= {17'd0, abs_s[31:16]};
      dq   <= {abs_s[15:0], 16'd0};
      dvs  <= abs_f;
      neg  <= second[31] ^ top_reg[31];
      step <= 5'd0;
    end
    if (ctl.div_step) begin
      rem  <= diff[32] ? rem_sh : diff;
      dq   <= {dq[30:0], ~diff[32]};
      step <= step + 5'd1;
    end
    if (ctl.div_fin) begin
      if (neg) begin
        sat <= (dq > Q_MIN);
        res <= (dq > Q_MIN) ? Q_MIN : qneg[31:0];
      end else begin
        sat <= dq[31];
        res <= dq[31] ? Q_MAX : dq;
      end
    end
  end

  assign count_ext   = {5'd0, count};
  assign done        = done_reg;
  assign status      = status_reg;
  assign stack_level = count_ext[4:0];
  assign top_value   = (count == '0) ? 32'sd0 : $signed(top_reg);

  `PSE_ASSERT_HOLD(a_count_bound, count <= CW'(STACK_DEPTH), "stack count beyond depth")
  `PSE_ASSERT_IMP(a_wb_two_entries, ctl.wb, !sts.lt2, "write-back with fewer than two entries")
  `PSE_ASSERT_IMP(a_push_not_full, ctl.push, !sts.full, "push onto full stack")

endmodule

@@ rtl/core/postfix_stack_evaluator.sv @@
// Top level of the postfix stack evaluator.
//
// Evaluates a postfix expression one request at a time. A request is taken at a
// rising edge with start high and busy low: command selects push, add, subtract,
// multiply or divide, and operand_value is the signed Q16.16 value for a push.
// Every request gives one result: done is high for exactly one cycle while
// top_value, stack_level and status hold the outcome. The receiver has no
// handshake and cannot stall; it must take the result in that cycle.
// Controller steps from accept to done; done is registered after each answer:
//   push, nop, underflow, overflow    answered in idle (the next request may follow)
//   add, subtract                     exec, write-back
//   multiply                          exec, multiply finish, write-back
//   divide by zero                    exec, answered there
//   divide with saturating quotient   exec, write-back
//   divide                            exec, divide loop, divide finish, write-back
// The divide runs a radix-2 restoring loop that retires one quotient bit
// per cycle. Operators read the entry below the top from the stack RAM,
// with a registered read; the top entry sits in a register. Synchronous reset
// empties the stack; no clearing pass runs on the RAM.
module postfix_stack_evaluator
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         command,
  input  logic signed [31:0] operand_value,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] top_value,
  output logic [4:0]         stack_level,
  output logic [2:0]         status
);

  ctl_t ctl;
  sts_t sts;

  pse_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy)
  );

  pse_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .operand_value (operand_value),
    .sts           (sts),
    .done          (done),
    .top_value     (top_value),
    .stack_level   (stack_level),
    .status        (status)
  );

endmodule

@@ test/tb_postfix_stack_evaluator.sv @@
// Testbench for the postfix stack evaluator: directed corners, then random token streams.
module tb_postfix_stack_evaluator;
  import pse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH          = 16;
  localparam int          SETTLE_CYCLES  = 48;
  localparam int          MAX_PRINTED    = 100;
  localparam longint      SAT_HI         = 64'sd2147483647;
  localparam longint      SAT_LO         = -64'sd2147483648;
  localparam logic [2:0]  CMD_SPARE_LAST = 3'd7;

  typedef struct {
    logic signed [31:0] top;
    logic [4:0]         level;
    logic [2:0]         code;
  } token_outcome_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic [2:0]         command;
  logic signed [31:0] operand_value;
  logic               busy;
  logic               done;
  logic signed [31:0] top_value;
  logic [4:0]         stack_level;
  logic [2:0]         status;

  logic signed [31:0] operand_stack [DEPTH];
  int                 operand_count;
  token_outcome_t     pending_outcomes [$];
  int                 mismatch_count;
  int                 sender_idle_pct;
  int                 shape_level;

  postfix_stack_evaluator #(
    .STACK_DEPTH(DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .operand_value(operand_value),
    .busy         (busy),
    .done         (done),
    .top_value    (top_value),
    .stack_level  (stack_level),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic token_outcome_t evaluate_token(input logic [2:0] cmd,
                                                     input logic signed [31:0] val);
    token_outcome_t res;
    longint         first;
    longint         second;
    longint         wide;
    logic           ok;
    logic           sat;
    res.code = ST_OK;
    if (cmd == CMD_PUSH) begin
      if (operand_count >= DEPTH) begin
        res.code = ST_OVER;
      end else begin
        operand_stack[operand_count] = val;
        operand_count++;
      end
    end else if (cmd <= CMD_DIV) begin
      if (operand_count < 2) begin
        res.code = ST_UNDER;
      end else begin
        first  = operand_stack[operand_count - 1];
        second = operand_stack[operand_count - 2];
        wide   = 0;
        ok     = 1'b1;
        sat    = 1'b0;
        case (cmd)
          CMD_ADD: wide = second + first;
          CMD_SUB: wide = second - first;
          CMD_MUL: wide = (second * first) / 65536;
          default: begin
            if (first == 0) ok = 1'b0;
            else wide = (second * 65536) / first;
          end
        endcase
        if (!ok) begin
          res.code = ST_DIVZ;
        end else begin
          if (wide > SAT_HI) begin
            wide = SAT_HI;
            sat  = 1'b1;
          end else if (wide < SAT_LO) begin
            wide = SAT_LO;
            sat  = 1'b1;
          end
          operand_stack[operand_count - 2] = wide[31:0];
          operand_count--;
          if (sat) res.code = ST_SAT;
        end
      end
    end
    res.top   = (operand_count > 0) ? operand_stack[operand_count - 1] : 32'sd0;
    res.level = operand_count[4:0];
    return res;
  endfunction

  task automatic log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("%0t MISMATCH %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    token_outcome_t want;
    if (!rst) begin
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          log_mismatch("result with no request outstanding");
        end else begin
          want = pending_outcomes.pop_front();
          if (top_value !== want.top)
            log_mismatch($sformatf("top_value %h, expected %h", top_value, want.top));
          if (stack_level !== want.level)
            log_mismatch($sformatf("stack_level %0d, expected %0d", stack_level, want.level));
          if (status !== want.code)
            log_mismatch($sformatf("status %0d, expected %0d", status, want.code));
        end
      end
      if (start && !busy) pending_outcomes.push_back(evaluate_token(command, operand_value));
    end
  end

  task automatic send_token(input logic [2:0] cmd, input logic signed [31:0] val);
    command       <= cmd;
    operand_value <= val;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == CMD_PUSH) begin
      if (shape_level < DEPTH) shape_level++;
    end else if (cmd <= CMD_DIV && shape_level >= 2) begin
      shape_level--;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic finish_phase();
    start <= 1'b0;
    do @(negedge clk); while (pending_outcomes.size() != 0);
    @(posedge clk);
    shape_level = operand_count;
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return 32'sd0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3, 4:    return $urandom;
      default: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  task automatic test_underflow_on_empty();
    send_token(CMD_ADD, $urandom);
    finish_phase();
  endtask

  task automatic test_fill_to_overflow();
    logic signed [31:0] fill_values [DEPTH] = '{
      32'h0001_8000, 32'hfffe_8000, 32'h5555_5555, 32'haaaa_aaaa,
      32'h0000_0001, 32'hffff_ffff, 32'h7fff_0000, 32'h8000_ffff,
      Q_MIN,         Q_MIN,         Q_MAX,         Q_MIN,
      32'h0000_0001, Q_MAX,         32'h0002_0000, 32'h0000_0000
    };
    foreach (fill_values[i]) send_token(CMD_PUSH, fill_values[i]);
    send_token(CMD_PUSH, $urandom);
    send_token(CMD_SPARE_LAST, $urandom);
    finish_phase();
  endtask

  task automatic test_operator_corners();
    logic [2:0] corner_ops [8] = '{
      CMD_DIV, CMD_SUB, CMD_MUL, CMD_ADD, CMD_SUB, CMD_DIV, CMD_DIV, CMD_MUL
    };
    foreach (corner_ops[i]) send_token(corner_ops[i], $urandom);
    finish_phase();
  endtask

  task automatic test_random_tokens(input int token_count, input int idle_pct,
                                    input int push_pct);
    int         sent;
    int         pick;
    logic [2:0] cmd;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < token_count) begin
      pick = $urandom_range(99);
      if (pick < 4)
        cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_DIV + 1));
      else if (shape_level < 2)
        cmd = (pick < 12) ? 3'($urandom_range(CMD_DIV, CMD_ADD)) : CMD_PUSH;
      else if (shape_level >= DEPTH)
        cmd = (pick < 30) ? CMD_PUSH : 3'($urandom_range(CMD_DIV, CMD_ADD));
      else
        cmd = (pick < push_pct) ? CMD_PUSH : 3'($urandom_range(CMD_DIV, CMD_ADD));
      send_token(cmd, pick_operand());
      if (cmd <= CMD_DIV) sent++;
    end
    finish_phase();
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    command         = CMD_PUSH;
    operand_value   = 32'sd0;
    operand_count   = 0;
    mismatch_count  = 0;
    shape_level     = 0;
    sender_idle_pct = 15;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_underflow_on_empty();
    test_fill_to_overflow();
    test_operator_corners();
    test_random_tokens(300, 15, 60);
    test_random_tokens(250, 62, 50);
    test_random_tokens(250, 0, 45);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("tb_postfix_stack_evaluator: done, clean");
    end else begin
      $display("tb_postfix_stack_evaluator: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_postfix_stack_evaluator: done, errors");
    $finish;
  end

endmodule

@@ postfix_stack_evaluator.f @@
+incdir+rtl/core
rtl/core/pse_pkg.sv
rtl/core/pse_ram.sv
rtl/core/pse_ctrl.sv
rtl/core/pse_dp.sv
rtl/core/postfix_stack_evaluator.sv
test/tb_postfix_stack_evaluator.sv
